/* rtl/core/nca_pkg.sv */
// Shared types and constants for the nearest-centroid assignment block.
`timescale 1ns / 1ps
package nca_pkg;

    localparam int MAX_CLUSTERS_DEF = 16;
    localparam int MAX_FEATURES_DEF = 16;

    localparam int CFG_DATA_W = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int DIST_W     = 36;
    localparam int VALUE_W    = 16;
    localparam int SQ_W       = 32;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_CLUSTERS = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_FEATURES = 1'b1;

    localparam logic [DIST_W-1:0] DIST_MAX = {DIST_W{1'b1}};

    localparam logic ACTION_CENTER = 1'b0;
    localparam logic ACTION_POINT  = 1'b1;

    typedef struct packed {
        logic                      action;
        logic [3:0]                cluster_index;
        logic [3:0]                feature_index;
        logic signed [VALUE_W-1:0] feature_value;
    } item_t;

    typedef struct packed {
        logic [3:0]        nearest_cluster;
        logic [DIST_W-1:0] min_distance;
    } result_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SEARCH,
        ST_DRAIN
    } ctl_state_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic accept;
        logic issue;
        logic first_f;
        logic last_f;
        logic first_c;
        logic last_c;
        logic load_out;
    } cmd_t;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic done;
        logic out_free;
    } status_t;

    // Per-stage tags that travel with each distance term.
    typedef struct packed {
        logic valid;
        logic first_f;
        logic last_f;
        logic first_c;
        logic last_c;
    } tag_t;

endpackage

/* rtl/core/nca_ctrl.sv */
// Controller: configuration registers, item handshake and search sequencing.
`timescale 1ns / 1ps
module nca_ctrl #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_FEATURES = 16,
    parameter int CW = $clog2(MAX_CLUSTERS),
    parameter int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    parameter int AW = $clog2(MAX_CLUSTERS * MAX_FEATURES)
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                item_valid,
    input  nca_pkg::item_t                      item,
    output logic                                item_stall,
    input  logic                                cfg_we,
    input  logic [nca_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [nca_pkg::CFG_DATA_W-1:0]      cfg_data,
    input  nca_pkg::status_t                    status,
    output nca_pkg::cmd_t                       cmd,
    output logic [AW-1:0]                       rd_addr,
    output logic [FW-1:0]                       rd_feat
);
    import nca_pkg::*;

    ctl_state_t            state_reg, state_next;
    logic [CFG_DATA_W-1:0] num_clusters_reg;
    logic [CFG_DATA_W-1:0] num_features_reg;
    logic [FW-1:0]         f_reg, f_next;
    logic [CW-1:0]         c_reg, c_next;
    logic [AW-1:0]         base_reg, base_next;
    logic [AW-1:0]         addr_reg, addr_next;
    logic [FW-1:0]         last_f;
    logic [CW-1:0]         last_c;
    logic                  accept;
    logic                  trigger;
    logic                  at_last_f;
    logic                  at_last_c;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            num_clusters_reg <= CFG_DATA_W'(1);
            num_features_reg <= CFG_DATA_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_NUM_CLUSTERS: num_clusters_reg <= cfg_data;
                REG_NUM_FEATURES: num_features_reg <= cfg_data;
                default:          num_clusters_reg <= num_clusters_reg;
            endcase
        end
    end

    always_comb
    begin
        if (num_clusters_reg == '0)
            last_c = '0;
        else if (int'(num_clusters_reg) > MAX_CLUSTERS)
            last_c = CW'(MAX_CLUSTERS - 1);
        else
            last_c = CW'(num_clusters_reg - CFG_DATA_W'(1));

        if (num_features_reg == '0)
            last_f = '0;
        else if (int'(num_features_reg) > MAX_FEATURES)
            last_f = FW'(MAX_FEATURES - 1);
        else
            last_f = FW'(num_features_reg - CFG_DATA_W'(1));
    end

    assign accept    = item_valid && (state_reg == ST_IDLE);
    assign trigger   = accept && (item.action == ACTION_POINT)
                       && (int'(item.feature_index) < MAX_FEATURES)
                       && (int'(item.feature_index) == int'(last_f));
    assign at_last_f = (f_reg == last_f);
    assign at_last_c = (c_reg == last_c);

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                    state_next = ST_SEARCH;
            end
            ST_SEARCH:
            begin
                if (at_last_f && at_last_c)
                    state_next = ST_DRAIN;
            end
            ST_DRAIN:
            begin
                if (status.done && status.out_free)
                    state_next = ST_IDLE;
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        item_stall = (state_reg != ST_IDLE);
        f_next     = f_reg;
        c_next     = c_reg;
        base_next  = base_reg;
        addr_next  = addr_reg;
        cmd.accept = accept;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (trigger)
                begin
                    f_next    = '0;
                    c_next    = '0;
                    base_next = '0;
                    addr_next = '0;
                end
            end
            ST_SEARCH:
            begin
                cmd.issue   = 1'b1;
                cmd.first_f = (f_reg == '0);
                cmd.first_c = (c_reg == '0);
                cmd.last_f  = at_last_f;
                cmd.last_c  = at_last_c;
                if (at_last_f)
                begin
                    f_next    = '0;
                    c_next    = c_reg + CW'(1);
                    base_next = AW'(int'(base_reg) + MAX_FEATURES);
                    addr_next = AW'(int'(base_reg) + MAX_FEATURES);
                end
                else
                begin
                    f_next    = f_reg + FW'(1);
                    addr_next = addr_reg + AW'(1);
                end
            end
            ST_DRAIN:
            begin
                cmd.load_out = status.done && status.out_free;
            end
            default: cmd = '0;
        endcase
    end

    assign rd_addr = addr_reg;
    assign rd_feat = f_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            f_reg     <= '0;
            c_reg     <= '0;
            base_reg  <= '0;
            addr_reg  <= '0;
        end
        else
        begin
            state_reg <= state_next;
            f_reg     <= f_next;
            c_reg     <= c_next;
            base_reg  <= base_next;
            addr_reg  <= addr_next;
        end
    end

endmodule

/* rtl/core/nca_datapath.sv */
// Datapath: center and point memories, distance pipeline, minimum search.
`timescale 1ns / 1ps
module nca_datapath #(
    parameter int MAX_CLUSTERS = 16,
    parameter int MAX_FEATURES = 16,
    parameter int CW = $clog2(MAX_CLUSTERS),
    parameter int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1,
    parameter int AW = $clog2(MAX_CLUSTERS * MAX_FEATURES)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  nca_pkg::item_t    item,
    input  nca_pkg::cmd_t     cmd,
    input  logic [AW-1:0]     rd_addr,
    input  logic [FW-1:0]     rd_feat,
    output nca_pkg::status_t  status,
    output logic              result_valid,
    input  logic              result_stall,
    output nca_pkg::result_t  result
);
    import nca_pkg::*;

    localparam int DEPTH = MAX_CLUSTERS * MAX_FEATURES;

    logic [VALUE_W-1:0] center_mem [DEPTH];
    logic [VALUE_W-1:0] point_mem  [MAX_FEATURES];

    logic               center_we;
    logic               point_we;
    logic [AW-1:0]      center_wr_addr;

    logic [VALUE_W-1:0]     center_q_reg;
    logic [VALUE_W-1:0]     point_q_reg;
    logic signed [16:0]     diff_reg;
    logic signed [33:0]     prod;
    logic [SQ_W-1:0]        sq_reg;
    logic [DIST_W:0]        sum_wide;
    logic [DIST_W-1:0]      acc_reg, acc_next;
    logic [DIST_W-1:0]      best_reg;
    logic [CW-1:0]          best_c_reg;
    logic [CW-1:0]          cmp_c_reg;
    logic                   done_reg;
    tag_t                   s1_reg, s2_reg, s3_reg, s4_reg;
    tag_t                   issue_tag;
    logic                   result_valid_reg;
    result_t                result_reg;
    logic                   cmp_fire;

    assign center_we = cmd.accept && (item.action == ACTION_CENTER)
                       && (int'(item.cluster_index) < MAX_CLUSTERS)
                       && (int'(item.feature_index) < MAX_FEATURES);
    assign point_we  = cmd.accept && (item.action == ACTION_POINT)
                       && (int'(item.feature_index) < MAX_FEATURES);
    assign center_wr_addr = AW'(int'(item.cluster_index) * MAX_FEATURES
                                + int'(item.feature_index));

    always_ff @(posedge clk)
    begin
        if (center_we)
            center_mem[center_wr_addr] <= item.feature_value;
        if (point_we)
            point_mem[FW'(item.feature_index)] <= item.feature_value;
        center_q_reg <= center_mem[rd_addr];
        point_q_reg  <= point_mem[rd_feat];
    end

    assign issue_tag = '{valid:   cmd.issue,
                         first_f: cmd.first_f,
                         last_f:  cmd.last_f,
                         first_c: cmd.first_c,
                         last_c:  cmd.last_c};

    assign prod = diff_reg * diff_reg;

    always_ff @(posedge clk)
    begin
        diff_reg <= $signed({point_q_reg[VALUE_W-1], point_q_reg})
                    - $signed({center_q_reg[VALUE_W-1], center_q_reg});
        sq_reg   <= prod[SQ_W-1:0];
    end

    // Accumulation saturates at the largest 36-bit value.
    always_comb
    begin
        sum_wide = {1'b0, acc_reg} + (DIST_W + 1)'(sq_reg);
        if (s3_reg.first_f)
            acc_next = DIST_W'(sq_reg);
        else if (sum_wide[DIST_W])
            acc_next = DIST_MAX;
        else
            acc_next = sum_wide[DIST_W-1:0];
    end

    assign cmp_fire = s4_reg.valid && s4_reg.last_f;

    always_ff @(posedge clk)
    begin
        if (s3_reg.valid)
            acc_reg <= acc_next;
        if (cmp_fire && (s4_reg.first_c || (acc_reg < best_reg)))
        begin
            best_reg   <= acc_reg;
            best_c_reg <= s4_reg.first_c ? CW'(0) : cmp_c_reg;
        end
        if (cmd.load_out)
        begin
            result_reg.nearest_cluster <= 4'(best_c_reg);
            result_reg.min_distance    <= best_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg           <= '0;
            s2_reg           <= '0;
            s3_reg           <= '0;
            s4_reg           <= '0;
            cmp_c_reg        <= '0;
            done_reg         <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            s1_reg <= issue_tag;
            s2_reg <= s1_reg;
            s3_reg <= s2_reg;
            s4_reg <= s3_reg;
            if (cmp_fire)
                cmp_c_reg <= s4_reg.first_c ? CW'(1) : cmp_c_reg + CW'(1);
            if (cmp_fire && s4_reg.last_c)
                done_reg <= 1'b1;
            else if (cmd.load_out)
                done_reg <= 1'b0;
            if (cmd.load_out)
                result_valid_reg <= 1'b1;
            else if (!result_stall)
                result_valid_reg <= 1'b0;
        end
    end

    assign status.done     = done_reg;
    assign status.out_free = !result_valid_reg || !result_stall;
    assign result_valid    = result_valid_reg;
    assign result          = result_reg;

    a_load_into_free_output: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |-> (!result_valid_reg || !result_stall))
        else $error("result register overwritten while still held");

    a_final_compare_not_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (cmp_fire && s4_reg.last_c) |-> !done_reg)
        else $error("search finished while a previous result was pending");

    a_no_issue_while_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.issue |-> !done_reg)
        else $error("search issued while a finished result was not yet loaded");

    a_load_needs_done: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load_out |=> result_valid_reg && !done_reg)
        else $error("result load did not complete");

endmodule

/* rtl/core/nearest_centroid_assign.sv */
// Top level of the nearest-centroid assignment block.
//
// Items arrive on item_valid/item_stall with payload item. Action 0 writes
// one center coordinate, action 1 writes one point coordinate. Neither
// produces a result, except a point coordinate whose index equals
// num_features-1, which starts the search over the stored point.
// The search walks num_clusters*num_features center coordinates, one per
// cycle, through a five-stage read, subtract, square, accumulate and compare
// pipeline. The result is loaded into the output register once the search
// has finished and that register is free, and item_stall stays high from
// the triggering item until that load.
// The result sits in an output register; while the receiver holds
// result_stall high, new items are still taken, and a further search runs
// but waits at its end until the output register is free.
// Reset sets both configuration registers to 1 and empties the pipeline and
// output register; the center table and point buffer are not cleared and
// must be written before they are searched. Configuration writes on
// cfg_we/cfg_index/cfg_data take effect at once and belong only to idle time.
`timescale 1ns / 1ps
module nearest_centroid_assign #(
    parameter int MAX_CLUSTERS = nca_pkg::MAX_CLUSTERS_DEF,
    parameter int MAX_FEATURES = nca_pkg::MAX_FEATURES_DEF
) (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            item_valid,
    output logic                            item_stall,
    input  nca_pkg::item_t                  item,
    output logic                            result_valid,
    input  logic                            result_stall,
    output nca_pkg::result_t                result,
    input  logic                            cfg_we,
    input  logic [nca_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [nca_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import nca_pkg::*;

    localparam int CW = $clog2(MAX_CLUSTERS);
    localparam int FW = (MAX_FEATURES > 1) ? $clog2(MAX_FEATURES) : 1;
    localparam int AW = $clog2(MAX_CLUSTERS * MAX_FEATURES);

    cmd_t          cmd;
    status_t       status;
    logic [AW-1:0] rd_addr;
    logic [FW-1:0] rd_feat;

    nca_ctrl #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_FEATURES (MAX_FEATURES),
        .CW           (CW),
        .FW           (FW),
        .AW           (AW)
    ) u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item       (item),
        .item_stall (item_stall),
        .cfg_we     (cfg_we),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .status     (status),
        .cmd        (cmd),
        .rd_addr    (rd_addr),
        .rd_feat    (rd_feat)
    );

    nca_datapath #(
        .MAX_CLUSTERS (MAX_CLUSTERS),
        .MAX_FEATURES (MAX_FEATURES),
        .CW           (CW),
        .FW           (FW),
        .AW           (AW)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .item         (item),
        .cmd          (cmd),
        .rd_addr      (rd_addr),
        .rd_feat      (rd_feat),
        .status       (status),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

endmodule

/* sim/nearest_centroid_assign_tb.sv */
// Self-checking testbench for the nearest-centroid assignment block.
`timescale 1ns / 1ps
module nearest_centroid_assign_tb;
    import nca_pkg::*;

    localparam int QUIET_LIMIT = 4000;
    localparam int HOLD_CYCLES = 400;
    localparam int PHASE_ITEMS = 130;
    localparam int NUM_PHASES  = 10;

    typedef struct {
        bit                    is_cfg;
        logic [CFG_IDX_W-1:0]  reg_sel;
        logic [CFG_DATA_W-1:0] reg_val;
        item_t                 it;
        bit                    has_res;
        result_t               res;
    } step_row_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  item_valid = 1'b0;
    logic                  item_stall;
    item_t                 item = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    logic signed [VALUE_W-1:0] center_mem [16][16];
    logic signed [VALUE_W-1:0] point_mem [16];
    logic [CFG_DATA_W-1:0]     cur_clusters = 5'd1;
    logic [CFG_DATA_W-1:0]     cur_features = 5'd1;

    result_t   pending_nearest [$];
    result_t   due;
    step_row_t plan [$];

    bit gaps_on = 1'b0;
    bit stalls_on = 1'b0;
    bit hold_request = 1'b0;
    int items_sent = 0;
    int results_checked = 0;
    int mismatch_count = 0;
    int quiet_cycles = 0;

    nearest_centroid_assign dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cfg_we       (cfg_we),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always #1 clk = ~clk;

    function automatic int clamp_count(input logic [CFG_DATA_W-1:0] v);
        if (v < 1) return 1;
        if (v > 16) return 16;
        return int'(v);
    endfunction

    function automatic bit nearest_center(input item_t it, output result_t r);
        int     nc;
        int     nf;
        longint best;
        longint sq_sum;
        longint diff;
        nc = clamp_count(cur_clusters);
        nf = clamp_count(cur_features);
        r = '0;
        best = 0;
        if (it.action == ACTION_CENTER)
        begin
            center_mem[it.cluster_index][it.feature_index] = it.feature_value;
            return 1'b0;
        end
        point_mem[it.feature_index] = it.feature_value;
        if (int'(it.feature_index) != nf - 1) return 1'b0;
        for (int c = 0; c < nc; c++)
        begin
            sq_sum = 0;
            for (int f = 0; f < nf; f++)
            begin
                diff = longint'(point_mem[f]) - longint'(center_mem[c][f]);
                sq_sum += diff * diff;
                if (sq_sum > DIST_MAX) sq_sum = DIST_MAX;
            end
            if (c == 0 || sq_sum < best)
            begin
                best = sq_sum;
                r.nearest_cluster = 4'(c);
            end
        end
        r.min_distance = best[DIST_W-1:0];
        return 1'b1;
    endfunction

    function automatic item_t make_item(input logic action, input logic [3:0] ci,
                                        input logic [3:0] fi,
                                        input logic signed [VALUE_W-1:0] v);
        item_t it;
        it.action = action;
        it.cluster_index = ci;
        it.feature_index = fi;
        it.feature_value = v;
        return it;
    endfunction

    function automatic logic signed [VALUE_W-1:0] rand_value();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7fff;
            2, 3: return 16'(int'($urandom_range(0, 6)) - 3);
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic step_row_t cfg_row(input logic [CFG_IDX_W-1:0] sel,
                                          input logic [CFG_DATA_W-1:0] v);
        step_row_t r;
        r = '{default: '0};
        r.is_cfg = 1'b1;
        r.reg_sel = sel;
        r.reg_val = v;
        return r;
    endfunction

    function automatic step_row_t item_row(input item_t it);
        step_row_t r;
        r = '{default: '0};
        r.it = it;
        return r;
    endfunction

    function automatic step_row_t check_row(input item_t it, input logic [3:0] cl,
                                            input logic [DIST_W-1:0] d);
        step_row_t r;
        r = item_row(it);
        r.has_res = 1'b1;
        r.res.nearest_cluster = cl;
        r.res.min_distance = d;
        return r;
    endfunction

    task automatic push_item(input item_t it, input bit has_res = 1'b0,
                             input result_t res = '0);
        result_t predicted;
        if (gaps_on && $urandom_range(0, 4) == 0)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
        item_valid <= 1'b1;
        item <= it;
        do @(posedge clk); while (item_stall);
        items_sent++;
        if (nearest_center(it, predicted))
            pending_nearest.push_back(has_res ? res : predicted);
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge clk);
        repeat (8) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] sel,
                             input logic [CFG_DATA_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_index <= sel;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        if (sel == REG_NUM_CLUSTERS) cur_clusters = v;
        else cur_features = v;
        @(posedge clk);
    endtask

    task automatic run_phase(input int raw_nc, input int raw_nf);
        int nc;
        int nf;
        int start;
        int kind;
        int c;
        int count;
        wait_idle();
        write_reg(REG_NUM_CLUSTERS, 5'(raw_nc));
        write_reg(REG_NUM_FEATURES, 5'(raw_nf));
        nc = clamp_count(5'(raw_nc));
        nf = clamp_count(5'(raw_nf));
        start = items_sent;
        while (items_sent - start < PHASE_ITEMS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 55)
            begin
                // A point, sometimes reusing buffered coordinates from earlier points.
                for (int f = 0; f < nf; f++)
                    if (f == nf - 1 || $urandom_range(0, 3) != 0)
                        push_item(make_item(ACTION_POINT, 4'($urandom), 4'(f),
                                            rand_value()));
            end
            else if (kind < 80)
            begin
                c = $urandom_range(0, nc - 1);
                count = $urandom_range(1, nf);
                for (int f = 0; f < count; f++)
                    push_item(make_item(ACTION_CENTER, 4'(c), 4'($urandom_range(0, nf - 1)),
                                        rand_value()));
            end
            else if (kind < 85)
            begin
                // Widest possible differences on every coordinate.
                for (int f = 0; f < nf; f++)
                    push_item(make_item(ACTION_CENTER, 4'd0, 4'(f), 16'sh8000));
                for (int f = 0; f < nf; f++)
                    push_item(make_item(ACTION_POINT, 4'($urandom), 4'(f), 16'sh7fff));
            end
            else if (kind < 95 && nf < 16)
            begin
                push_item(make_item(ACTION_POINT, 4'($urandom), 4'($urandom_range(nf, 15)),
                                    rand_value()));
            end
            else
            begin
                push_item(make_item(1'($urandom), 4'($urandom), 4'($urandom),
                                    16'($urandom)));
            end
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
        begin
            results_checked++;
            if (pending_nearest.size() == 0)
            begin
                mismatch_count++;
                $display("%0t: unexpected result, cluster %0d distance %0d", $time,
                         result.nearest_cluster, result.min_distance);
            end
            else
            begin
                due = pending_nearest.pop_front();
                if (result.nearest_cluster !== due.nearest_cluster)
                begin
                    mismatch_count++;
                    $display("%0t: nearest_cluster expected %0d actual %0d", $time,
                             due.nearest_cluster, result.nearest_cluster);
                end
                if (result.min_distance !== due.min_distance)
                begin
                    mismatch_count++;
                    $display("%0t: min_distance expected %0d actual %0d", $time,
                             due.min_distance, result.min_distance);
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((item_valid && !item_stall) || (result_valid && !result_stall))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
                $display("CHECK FAILED");
                $finish;
            end
        end
    end

    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                result_stall <= 1'b0;
            end
            else if (stalls_on && $urandom_range(0, 5) == 0)
            begin
                result_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                result_stall <= 1'b0;
            end
        end
    end

    initial
    begin
        int phase_nc [NUM_PHASES] = '{1, 16, 0, 31, 16, 5, 2, 9, 3, 16};
        int phase_nf [NUM_PHASES] = '{16, 16, 0, 31, 1, 7, 3, 4, 12, 16};
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        gaps_on = 1'b1;
        stalls_on = 1'b1;

        // The center table and point buffer must be written before any search reads them.
        for (int c = 0; c < 16; c++)
            for (int f = 0; f < 16; f++)
                push_item(make_item(ACTION_CENTER, 4'(c), 4'(f), 16'sd0));
        for (int f = 0; f < 16; f++)
            push_item(make_item(ACTION_POINT, 4'($urandom), 4'(f), 16'sd0));

        plan.push_back(cfg_row(REG_NUM_CLUSTERS, 5'd2));
        plan.push_back(cfg_row(REG_NUM_FEATURES, 5'd2));
        plan.push_back(item_row(make_item(ACTION_POINT, 4'hf, 4'd0, 16'sd0)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'hf, 4'd1, 16'sd0), 4'd0, 36'd0));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd1, 4'd0, -16'sd5)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'h0, 4'd1, 16'sd0), 4'd0, 36'd0));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd0, 4'd0, 16'sd5)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'h5, 4'd1, 16'sd0), 4'd0, 36'd25));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd1, 4'd1, 16'sd1)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'ha, 4'd1, 16'sd0), 4'd0, 36'd25));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd0, 4'd1, 16'sd2)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'h3, 4'd1, 16'sd0), 4'd1, 36'd26));
        plan.push_back(item_row(make_item(ACTION_POINT, 4'hc, 4'd3, 16'sd7)));
        plan.push_back(item_row(make_item(ACTION_POINT, 4'h0, 4'd0, -16'sd5)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'hf, 4'd1, 16'sd1), 4'd1, 36'd0));
        plan.push_back(cfg_row(REG_NUM_CLUSTERS, 5'd1));
        plan.push_back(cfg_row(REG_NUM_FEATURES, 5'd1));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd0, 4'd0, 16'sh8000)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'hf, 4'd0, 16'sh7fff), 4'd0,
                                 36'd4294836225));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'h0, 4'd0, 16'sh8000), 4'd0, 36'd0));
        plan.push_back(cfg_row(REG_NUM_CLUSTERS, 5'd31));
        plan.push_back(cfg_row(REG_NUM_FEATURES, 5'd0));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'hf, 4'd0, 16'sd4), 4'd2, 36'd16));
        plan.push_back(item_row(make_item(ACTION_CENTER, 4'd15, 4'd0, 16'sd4)));
        plan.push_back(check_row(make_item(ACTION_POINT, 4'h6, 4'd0, 16'sd4), 4'd15, 36'd0));

        foreach (plan[i])
        begin
            if (plan[i].is_cfg)
            begin
                wait_idle();
                write_reg(plan[i].reg_sel, plan[i].reg_val);
            end
            else
            begin
                push_item(plan[i].it, plan[i].has_res, plan[i].res);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            gaps_on = !(p == 4 || p == NUM_PHASES - 1);
            stalls_on = gaps_on;
            if (p >= 6 && p < NUM_PHASES - 1)
            begin
                phase_nc[p] = $urandom_range(0, 31);
                phase_nf[p] = $urandom_range(0, 31);
            end
            if (p == 2)
            begin
                // Start the long hold only once nothing is pending, so items keep coming.
                wait_idle();
                hold_request = 1'b1;
            end
            run_phase(phase_nc[p], phase_nf[p]);
        end

        item_valid <= 1'b0;
        while (pending_nearest.size() != 0) @(posedge clk);
        repeat (300) @(posedge clk);
        $display("Sent %0d items over %0d register settings; checked %0d search results.",
                 items_sent, NUM_PHASES + 3, results_checked);
        $display("Covered ties, clamped counts, points past the count and widest distances.");
        if (mismatch_count == 0)
        begin
            $display("CHECK OK");
        end
        else
        begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
